FILE: rtl/spfa_pkg.sv
`timescale 1ns / 1ps

package spfa_pkg;

  // Graph store dimensions
  localparam int MaxVertices = 2048;
  localparam int MaxEdges    = 8192;
  localparam int VtxW        = $clog2(MaxVertices);   // vertex index bits
  localparam int EdgeAw      = $clog2(MaxEdges);      // edge memory address bits
  localparam int EdgeIdW     = EdgeAw + 1;            // edge number, 0 ends a list
  localparam int CountW      = 13;                    // enqueue count, holds limit + 1
  localparam int FillW       = VtxW + 1;

  localparam logic [31:0] DIST_INIT = 32'h3f3f_3f3f;
  localparam logic [EdgeIdW-1:0] EDGE_FULL = EdgeIdW'(MaxEdges);

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0_0000_0000_0001,
    ST_RD    = 13'b0_0000_0000_0010,
    ST_WR    = 13'b0_0000_0000_0100,
    ST_START = 13'b0_0000_0000_1000,
    ST_POP   = 13'b0_0000_0001_0000,
    ST_POP2  = 13'b0_0000_0010_0000,
    ST_HEAD  = 13'b0_0000_0100_0000,
    ST_EDGE  = 13'b0_0000_1000_0000,
    ST_CMP   = 13'b0_0001_0000_0000,
    ST_FIN   = 13'b0_0010_0000_0000,
    ST_CLR   = 13'b0_0100_0000_0000,
    ST_SPARE = 13'b0_1000_0000_0000,
    ST_SPAR2 = 13'b1_0000_0000_0000
  } state_t;

endpackage

FILE: rtl/spfa_negative_cycle_detect.sv
`timescale 1ns / 1ps

// Channel   | Dir | Fields (lowest bit first)
// s_axis    | in  | tdata: from_vertex[11:0], to_vertex[23:12], weight[39:24]; tlast: last_edge
// m_axis    | out | tdata: negative_cycle[0], store_overflow[1], zero[7:2]
// cfg       | in  | cfg_wr_data: vertex_count
//
// An edge runs ST_RD then ST_WR, the read-modify-write of the list head memory, once for
// each stored direction; a weight that is not negative stores both directions (two-way).
// The search after the last edge runs ST_POP, ST_POP2, ST_HEAD per queue pop and ST_EDGE,
// ST_CMP per edge scanned. After each result, and after reset, a clearing pass runs over every
// vertex memory entry with s_axis_tready low. A result waits in the output register until taken.
module spfa_negative_cycle_detect import spfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,      // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,     // from_vertex, to_vertex, weight
  input  logic        s_axis_tlast,     // last_edge
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata      // negative_cycle, store_overflow, zero pad
);

  // Memories
  logic [EdgeIdW-1:0] list_head  [MaxVertices];
  logic [EdgeIdW-1:0] edge_next  [MaxEdges];
  logic [VtxW-1:0]    edge_target[MaxEdges];
  logic [15:0]        edge_weight[MaxEdges];
  logic [31:0]        distance   [MaxVertices];
  logic               queued_mark[MaxVertices];
  logic [CountW-1:0]  enq_count  [MaxVertices];
  logic [VtxW-1:0]    work_queue [MaxVertices];

  // Control and datapath registers
  state_t             state;
  logic [11:0]        vertex_count;
  logic [EdgeIdW-1:0] edges_stored;
  logic               overflow_seen;
  logic [VtxW-1:0]    src, dst;
  logic [15:0]        wt;
  logic               two_way, last, second;
  logic [VtxW-1:0]    clr_idx;
  logic [VtxW-1:0]    rptr;
  logic [FillW-1:0]   fill;
  logic [VtxW-1:0]    cur_t, cur_j;
  logic [31:0]        dt, sum;
  logic [EdgeIdW-1:0] nxt;
  logic               neg_found;

  // Registered read data
  logic [EdgeIdW-1:0] head_rd, next_rd;
  logic [VtxW-1:0]    tgt_rd, q_rd;
  logic [15:0]        w_rd;
  logic [31:0]        dist_rd;
  logic               mark_rd;
  logic [CountW-1:0]  cnt_rd;

  logic [VtxW-1:0]    head_addr, dist_addr, wr_src, wr_dst;
  logic [EdgeIdW-1:0] edge_sel, e_new;
  logic [EdgeAw-1:0]  edge_raddr;
  logic               in_ok;
  logic [11:0]        in_from, in_to;
  logic [32:0]        sum_w;
  logic [31:0]        sum_sat;
  logic               relax, push, limit_hit;
  logic [CountW-1:0]  cnt_after;
  logic [VtxW-1:0]    push_slot;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_from = s_axis_tdata[11:0];
  assign in_to   = s_axis_tdata[23:12];
  assign in_ok   = (in_from != 12'd0) && (in_from <= 12'(MaxVertices)) &&
                   (in_to != 12'd0) && (in_to <= 12'(MaxVertices));

  // Direction being stored
  assign wr_src = second ? dst : src;
  assign wr_dst = second ? src : dst;
  assign e_new  = edges_stored + EdgeIdW'(1);

  // Shared read addresses
  assign head_addr  = (state == ST_POP2) ? q_rd : wr_src;
  assign dist_addr  = (state == ST_POP2) ? q_rd : tgt_rd;
  assign edge_sel   = (state == ST_HEAD) ? head_rd : nxt;
  assign edge_raddr = EdgeAw'(edge_sel - EdgeIdW'(1));

  // Saturated distance plus weight
  always_comb begin
    sum_w = {dt[31], dt} + {{17{w_rd[15]}}, w_rd};
    if (sum_w[32] != sum_w[31]) begin
      sum_sat = sum_w[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sum_sat = sum_w[31:0];
    end
  end

  // Relaxation decision
  assign relax     = $signed(dist_rd) > $signed(sum);
  assign push      = relax && !mark_rd;
  assign cnt_after = push ? cnt_rd + CountW'(1) : cnt_rd;
  assign limit_hit = relax && (cnt_after > {1'b0, vertex_count});
  assign push_slot = VtxW'(rptr + VtxW'(fill));

  // Head list memory
  always_ff @(posedge clk) begin
    head_rd <= list_head[head_addr];
    if (state == ST_CLR) begin
      list_head[clr_idx] <= '0;
    end else if (state == ST_WR && edges_stored < EDGE_FULL) begin
      list_head[wr_src] <= e_new;
    end
  end

  // Edge memories
  always_ff @(posedge clk) begin
    next_rd <= edge_next[edge_raddr];
    tgt_rd  <= edge_target[edge_raddr];
    w_rd    <= edge_weight[edge_raddr];
    if (state == ST_WR && edges_stored < EDGE_FULL) begin
      edge_next[EdgeAw'(edges_stored)]   <= head_rd;
      edge_target[EdgeAw'(edges_stored)] <= wr_dst;
      edge_weight[EdgeAw'(edges_stored)] <= wt;
    end
  end

  // Distance memory
  always_ff @(posedge clk) begin
    dist_rd <= distance[dist_addr];
    if (state == ST_CLR) begin
      distance[clr_idx] <= DIST_INIT;
    end else if (state == ST_START) begin
      distance[0] <= '0;
    end else if (state == ST_CMP && relax) begin
      distance[cur_j] <= sum;
    end
  end

  // Queued mark memory
  always_ff @(posedge clk) begin
    mark_rd <= queued_mark[tgt_rd];
    if (state == ST_CLR) begin
      queued_mark[clr_idx] <= 1'b0;
    end else if (state == ST_START) begin
      queued_mark[0] <= 1'b1;
    end else if (state == ST_POP2) begin
      queued_mark[q_rd] <= 1'b0;
    end else if (state == ST_CMP && push) begin
      queued_mark[cur_j] <= 1'b1;
    end
  end

  // Enqueue count memory
  always_ff @(posedge clk) begin
    cnt_rd <= enq_count[tgt_rd];
    if (state == ST_CLR) begin
      enq_count[clr_idx] <= '0;
    end else if (state == ST_START) begin
      enq_count[0] <= CountW'(1);
    end else if (state == ST_CMP && push) begin
      enq_count[cur_j] <= cnt_after;
    end
  end

  // Work queue ring
  always_ff @(posedge clk) begin
    q_rd <= work_queue[rptr];
    if (state == ST_START) begin
      work_queue[0] <= '0;
    end else if (state == ST_CMP && push) begin
      work_queue[push_slot] <= cur_j;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 12'd1;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_idx       <= '0;
      edges_stored  <= '0;
      overflow_seen <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      rptr          <= '0;
      fill          <= '0;
      second        <= 1'b0;
      neg_found     <= 1'b0;
    end else begin
      // release a taken result
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            src     <= VtxW'(in_from - 12'd1);
            dst     <= VtxW'(in_to - 12'd1);
            wt      <= s_axis_tdata[39:24];
            two_way <= !s_axis_tdata[39];
            last    <= s_axis_tlast;
            second  <= 1'b0;
            if (in_ok) begin
              state <= ST_RD;
            end else if (s_axis_tlast) begin
              state <= ST_START;
            end
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          // link one direction, or drop it when full
          if (edges_stored < EDGE_FULL) begin
            edges_stored <= e_new;
          end else begin
            overflow_seen <= 1'b1;
          end
          if (two_way && !second) begin
            second <= 1'b1;
            state  <= ST_RD;
          end else begin
            state <= last ? ST_START : ST_IDLE;
          end
        end
        ST_START: begin
          rptr  <= '0;
          fill  <= FillW'(1);
          state <= ST_POP;
        end
        ST_POP: begin
          if (fill == '0) begin
            neg_found <= 1'b0;
            state     <= ST_FIN;
          end else begin
            state <= ST_POP2;
          end
        end
        ST_POP2: begin
          cur_t <= q_rd;
          rptr  <= rptr + VtxW'(1);
          fill  <= fill - FillW'(1);
          state <= ST_HEAD;
        end
        ST_HEAD: begin
          dt    <= dist_rd;
          nxt   <= head_rd;
          state <= (head_rd == '0) ? ST_POP : ST_EDGE;
        end
        ST_EDGE: begin
          cur_j <= tgt_rd;
          sum   <= sum_sat;
          nxt   <= next_rd;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (push) begin
            fill <= fill + FillW'(1);
          end
          // self loop lowers the current vertex too
          if (relax && cur_j == cur_t) begin
            dt <= sum;
          end
          if (limit_hit) begin
            neg_found <= 1'b1;
            state     <= ST_FIN;
          end else begin
            state <= (nxt == '0) ? ST_POP : ST_EDGE;
          end
        end
        ST_FIN: begin
          // hold until the previous result is gone
          if (!m_axis_tvalid) begin
            m_axis_tvalid   <= 1'b1;
            m_axis_tdata[0] <= neg_found;
            m_axis_tdata[1] <= overflow_seen;
            m_axis_tdata[7:2] <= '0;
            edges_stored    <= '0;
            overflow_seen   <= 1'b0;
            clr_idx         <= '0;
            state           <= ST_CLR;
          end
        end
        ST_CLR: begin
          clr_idx <= clr_idx + VtxW'(1);
          if (clr_idx == VtxW'(MaxVertices - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLR;
        end
      endcase
    end
  end

endmodule

FILE: dv/tb_spfa_negative_cycle_detect.sv
`timescale 1ns / 1ps

module tb_spfa_negative_cycle_detect;
  import spfa_pkg::MaxVertices;
  import spfa_pkg::MaxEdges;
  import spfa_pkg::DIST_INIT;

  localparam int CycleLimit = 20_000_000;

  typedef struct packed {
    logic neg_cycle;
    logic overflow;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // from_vertex[11:0], to_vertex[23:12], weight[39:24]
  logic        s_axis_tlast = 1'b0; // last_edge
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // negative_cycle[0], store_overflow[1], zero[7:2]

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int unsigned cycles = 0;

  // Predictor state: graph store and limit
  int unsigned limit_vc = 1;
  int unsigned head_of[MaxVertices];
  int unsigned link_next[MaxEdges + 1];
  int unsigned link_dst[MaxEdges + 1];
  int          link_w[MaxEdges + 1];
  int unsigned links_used = 0;
  bit          dropped = 1'b0;

  // Search scratch
  int          dist_of[MaxVertices];
  bit          in_queue[MaxVertices];
  int unsigned push_cnt[MaxVertices];
  int unsigned ring[MaxVertices];
  int unsigned ring_rd;
  int unsigned ring_fill;

  verdict_t verdicts_due[$];

  spfa_negative_cycle_detect u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Link one directed edge, flag it when the store is full
  function automatic void link_edge(int unsigned src, int unsigned dst, int w);
    if (links_used >= MaxEdges) begin
      dropped = 1'b1;
      return;
    end
    links_used++;
    link_next[links_used] = head_of[src];
    link_dst[links_used] = dst;
    link_w[links_used] = w;
    head_of[src] = links_used;
  endfunction

  function automatic void push_vtx(int unsigned v);
    ring[(ring_rd + ring_fill) % MaxVertices] = v;
    ring_fill++;
    in_queue[v] = 1'b1;
    push_cnt[v]++;
  endfunction

  // Queue-based relaxation from vertex 1; 1 means the enqueue limit was passed
  function automatic bit find_neg_cycle();
    int unsigned t;
    int unsigned e;
    int unsigned j;
    longint sum;
    for (int v = 0; v < MaxVertices; v++) begin
      dist_of[v] = DIST_INIT;
      in_queue[v] = 1'b0;
      push_cnt[v] = 0;
    end
    ring_rd = 0;
    ring_fill = 0;
    dist_of[0] = 0;
    push_vtx(0);
    while (ring_fill != 0) begin
      t = ring[ring_rd];
      ring_rd = (ring_rd + 1) % MaxVertices;
      ring_fill--;
      in_queue[t] = 1'b0;
      e = head_of[t];
      while (e != 0) begin
        j = link_dst[e];
        sum = longint'(dist_of[t]) + longint'(link_w[e]);
        if (sum < -longint'(64'h8000_0000)) sum = -longint'(64'h8000_0000);
        if (sum > longint'(32'h7fff_ffff)) sum = longint'(32'h7fff_ffff);
        if (longint'(dist_of[j]) > sum) begin
          dist_of[j] = int'(sum);
          if (!in_queue[j]) push_vtx(j);
          if (push_cnt[j] > limit_vc) return 1'b1;
        end
        e = link_next[e];
      end
    end
    return 1'b0;
  endfunction

  // Update the graph with one accepted edge and queue the verdict on the last one
  function automatic void absorb_edge(logic [11:0] src, logic [11:0] dst,
                                      logic signed [15:0] w, logic fin);
    verdict_t vd;
    if (src >= 1 && src <= MaxVertices && dst >= 1 && dst <= MaxVertices) begin
      link_edge(src - 1, dst - 1, int'(w));
      if (w >= 0) link_edge(dst - 1, src - 1, int'(w));
    end
    if (fin) begin
      vd.neg_cycle = find_neg_cycle();
      vd.overflow = dropped;
      verdicts_due.push_back(vd);
      for (int v = 0; v < MaxVertices; v++) head_of[v] = 0;
      links_used = 0;
      dropped = 1'b0;
    end
  endfunction

  // Send one edge, with random idle cycles ahead of it
  task automatic send_edge(logic [11:0] src, logic [11:0] dst, logic [15:0] w, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w, dst, src};
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
    absorb_edge(src, dst, w, fin);
  endtask

  // Drain outstanding verdicts, then write the vertex count with no edge in flight
  task automatic set_vertex_count(logic [11:0] vc);
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= vc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_vc = vc;
  endtask

  task automatic set_idling(int snd, int rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    // zero limit: first relaxation reports a cycle
    set_vertex_count(12'd0);
    send_edge(12'd1, 12'd2, 16'd5, 1'b1);
    set_vertex_count(12'd2);
    // two-way zero weight edge: no cycle
    send_edge(12'd1, 12'd2, 16'd0, 1'b1);
    // negative loop between vertices 1 and 2
    send_edge(12'd1, 12'd2, -16'sd3, 1'b0);
    send_edge(12'd2, 12'd1, -16'sd3, 1'b1);
    // out-of-range vertices are ignored
    send_edge(12'd0, 12'd2, 16'd1, 1'b0);
    send_edge(12'd1, 12'd0, -16'sd9, 1'b0);
    send_edge(12'd4095, 12'd1, -16'sd9, 1'b0);
    send_edge(12'd1, 12'd2049, -16'sd9, 1'b1);
    // extremes of vertex and weight
    send_edge(12'd1, 12'd2048, 16'sd32767, 1'b0);
    send_edge(12'd2048, 12'd3, -16'sd32768, 1'b0);
    send_edge(12'd3, 12'd2048, 16'sd32767, 1'b1);
    send_edge(12'd2048, 12'd1, -16'sd32768, 1'b0);
    send_edge(12'd1, 12'd2048, -16'sd32768, 1'b1);
    // vertices above the limit still take part
    send_edge(12'd1, 12'd7, 16'd2, 1'b0);
    send_edge(12'd7, 12'd9, 16'd1, 1'b0);
    send_edge(12'd9, 12'd1, -16'sd4, 1'b1);
  endtask

  // Fill the store exactly so that the closing two-way edge keeps one direction
  task automatic test_store_full();
    set_idling(0, 0);
    set_vertex_count(12'd3);
    for (int i = 0; i < MaxEdges / 2 - 1; i++)
      send_edge(12'd1, 12'd2, 16'd0, 1'b0);
    send_edge(12'd2, 12'd3, -16'sd1, 1'b0);
    send_edge(12'd3, 12'd1, 16'd4, 1'b1);
  endtask

  // Largest limit with a negative cycle: the longest search
  task automatic test_deep_limit();
    set_idling(28, 28);
    set_vertex_count(12'd4095);
    send_edge(12'd1, 12'd2, -16'sd1, 1'b0);
    send_edge(12'd2, 12'd1, -16'sd1, 1'b1);
    set_vertex_count(12'd2048);
    send_edge(12'd1, 12'd2, -16'sd32768, 1'b0);
    send_edge(12'd2, 12'd1, 16'sd32767, 1'b1);
  endtask

  function automatic logic [11:0] pick_vertex(int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 90) return 12'($urandom_range(span, 1));
    if (r < 95) return ($urandom_range(1)) ? 12'd0 : 12'($urandom_range(4095, 2049));
    return 12'($urandom);
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($signed($urandom_range(40)) - 10);
    if (r < 80) return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
    return 16'($urandom);
  endfunction

  // Random graphs of a few edges each
  task automatic test_random_graphs(int unsigned n_items, logic [11:0] vc,
                                    int snd, int rcv);
    int unsigned sent;
    int unsigned n_edges;
    int unsigned span;
    set_vertex_count(vc);
    set_idling(snd, rcv);
    span = (vc < 2) ? 3 : ((vc > 10) ? 10 : vc + 1);
    sent = 0;
    while (sent < n_items) begin
      n_edges = $urandom_range(12, 1);
      for (int i = 0; i < n_edges; i++)
        send_edge(pick_vertex(span), pick_vertex(span), pick_weight(),
                  i == n_edges - 1);
      sent += n_edges;
    end
  endtask

  // Receiver stalls and result check
  always @(posedge clk) begin
    verdict_t exp_v;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_v = verdicts_due.pop_front();
        if (m_axis_tdata[0] !== exp_v.neg_cycle) begin
          $display("%0t: negative_cycle expected %b actual %b", $time,
                   exp_v.neg_cycle, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[1] !== exp_v.overflow) begin
          $display("%0t: store_overflow expected %b actual %b", $time,
                   exp_v.overflow, m_axis_tdata[1]);
          errors++;
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_deep_limit();
    test_random_graphs(100, 12'd1, 0, 0);
    test_random_graphs(100, 12'd3, 73, 0);
    test_random_graphs(100, 12'd6, 0, 73);
    test_random_graphs(100, 12'd2048, 28, 28);
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: spfa_negative_cycle_detect.f
rtl/spfa_pkg.sv
rtl/spfa_negative_cycle_detect.sv
dv/tb_spfa_negative_cycle_detect.sv
